[hdl/wesp_pkg.sv]
package wesp_pkg;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = 31;
    localparam int DIM_W   = 11;
    localparam int SRC_W   = 10;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int OI_W    = 2 * DIM_W;
    localparam int PHASE_W = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_X      = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_Y      = 3'd3;
    localparam logic [IDX_W-1:0] REG_TAU_SQ      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SOURCE_ROW  = 3'd5;
    localparam logic [IDX_W-1:0] REG_SOURCE_COL  = 3'd6;

    // Neighborhood read phases.
    localparam logic [PHASE_W-1:0] RD_CENTER = 3'd0;
    localparam logic [PHASE_W-1:0] RD_RIGHT  = 3'd1;
    localparam logic [PHASE_W-1:0] RD_LEFT   = 3'd2;
    localparam logic [PHASE_W-1:0] RD_DOWN   = 3'd3;
    localparam logic [PHASE_W-1:0] RD_UP     = 3'd4;
    localparam logic [PHASE_W-1:0] RD_DONE   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM
    } wesp_state_t;

    typedef struct packed {
        logic                accept;
        logic                rd_go;
        logic [PHASE_W-1:0]  rd_idx;
        logic                mul1;
        logic                mul2;
        logic                mul3;
        logic                fin;
    } wesp_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic div_done;
        logic out_free;
    } wesp_status_t;

endpackage

[hdl/wesp_ram.sv]
module wesp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2052
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/wesp_div.sv]
module wesp_div #(
    parameter int N = 22,
    parameter int D = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder,
    output logic         done
);

    localparam int CNT_W = $clog2(N + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D:0]       rem_reg;
    logic [N-1:0]     quo_reg;
    logic [D:0]       rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[D-1:0], quo_reg[N-1]};
    assign ge     = rem_sh >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
            quo_reg <= {quo_reg[N-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg[D-1:0];
    assign done      = !busy_reg;

endmodule

[hdl/wesp_ctrl.sv]
module wesp_ctrl
    import wesp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  wesp_status_t status,
    output wesp_cmd_t    cmd
);

    wesp_state_t        state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                phase_next = RD_CENTER;
                if (in_valid && status.emit_req)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                phase_next = phase_reg + 1'b1;
                if (phase_reg == RD_DONE)
                begin
                    state_next = ST_WAIT_DIV;
                end
            end
            ST_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_SUM;
            ST_SUM:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ:
            begin
                cmd.rd_go  = phase_reg != RD_DONE;
                cmd.rd_idx = phase_reg;
            end
            ST_MUL1: cmd.mul1 = 1'b1;
            ST_MUL2: cmd.mul2 = 1'b1;
            ST_MUL3: cmd.mul3 = 1'b1;
            ST_SUM:  cmd.fin  = status.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= RD_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    a_read_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && phase_reg == RD_DONE) |=> state_reg == ST_WAIT_DIV)
        else $error("read sequence did not hand over to divider wait");

    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT_DIV && !status.div_done) |=> state_reg == ST_WAIT_DIV)
        else $error("arithmetic started before the divider finished");

endmodule

[hdl/wesp_dp.sv]
module wesp_dp
    import wesp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wesp_cmd_t           cmd,
    output wesp_status_t        status,
    input  logic                in_op,
    input  logic [DATA_W-1:0]   in_u_prev,
    input  logic [DATA_W-1:0]   in_u_old,
    input  logic [COEF_W-1:0]   in_medium_coef,
    input  logic [DATA_W-1:0]   in_source_amp,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   out_u_new,
    output logic                out_frame_end
);

    localparam int RING = 2 * MAX_WIDTH + 4;
    localparam int AW   = $clog2(RING);
    localparam int CW   = ((AW > DIM_W) ? AW : DIM_W) + 1;
    localparam logic [DIM_W-1:0] W_CLAMP =
        (MAX_WIDTH > 2047) ? 11'd2047 : DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_CLAMP =
        (MAX_HEIGHT > 2047) ? 11'd2047 : DIM_W'(MAX_HEIGHT);

    // Configuration registers.
    logic [DIM_W-1:0]  grid_w_reg, grid_h_reg;
    logic [CFG_W-1:0]  coef_x_reg, coef_y_reg, tau_sq_reg;
    logic [SRC_W-1:0]  src_row_reg, src_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg  <= 11'd1024;
            grid_h_reg  <= 11'd1024;
            coef_x_reg  <= '0;
            coef_y_reg  <= '0;
            tau_sq_reg  <= '0;
            src_row_reg <= 10'd1;
            src_col_reg <= 10'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_w_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: grid_h_reg  <= cfg_data[DIM_W-1:0];
                REG_COEF_X:      coef_x_reg  <= cfg_data;
                REG_COEF_Y:      coef_y_reg  <= cfg_data;
                REG_TAU_SQ:      tau_sq_reg  <= cfg_data;
                REG_SOURCE_ROW:  src_row_reg <= cfg_data[SRC_W-1:0];
                REG_SOURCE_COL:  src_col_reg <= cfg_data[SRC_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [DIM_W-1:0] eff_w, eff_h;

    assign eff_w = (grid_w_reg < 11'd3) ? 11'd3 :
                   (grid_w_reg > W_CLAMP) ? W_CLAMP : grid_w_reg;
    assign eff_h = (grid_h_reg < 11'd3) ? 11'd3 :
                   (grid_h_reg > H_CLAMP) ? H_CLAMP : grid_h_reg;

    // Input side bookkeeping.
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     pending_reg, pending_next;
    logic [AW-1:0]     p_reg;
    logic [DIM_W-1:0]  in_row_reg, in_row_next, in_col_reg, in_col_next;
    logic [OI_W-1:0]   out_index_reg, out_index_next;
    logic signed [DATA_W-1:0] src_latch_reg;
    logic              is_data, emit;
    logic [AW-1:0]     wr_inc, pend_inc, wr_new, pend_new, p_new;
    logic [AW:0]       p_wrap;
    logic              at_source;

    assign is_data  = !in_op;
    assign wr_inc   = (wr_ptr_reg == AW'(RING - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign pend_inc = (pending_reg < AW'(RING - 1)) ? pending_reg + 1'b1 : pending_reg;
    assign wr_new   = is_data ? wr_inc : wr_ptr_reg;
    assign pend_new = is_data ? pend_inc : pending_reg;
    assign emit     = is_data ? (CW'(pend_inc) > (CW'(eff_w) + CW'(1)))
                              : (pending_reg != '0);
    assign p_wrap   = (AW + 1)'(wr_new) + (AW + 1)'(RING) - (AW + 1)'(pend_new);
    assign p_new    = (wr_new >= pend_new) ? (wr_new - pend_new) : p_wrap[AW-1:0];
    assign at_source = (in_row_reg == DIM_W'(src_row_reg))
                    && (in_col_reg == DIM_W'(src_col_reg));

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        pending_next = pending_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        if (cmd.accept)
        begin
            wr_ptr_next  = wr_new;
            pending_next = emit ? (pend_new - 1'b1) : pend_new;
            if (is_data)
            begin
                if ((12'(in_col_reg) + 12'd1) >= 12'(eff_w))
                begin
                    in_col_next = '0;
                    in_row_next = ((12'(in_row_reg) + 12'd1) >= 12'(eff_h)) ?
                                  '0 : in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            pending_reg   <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_index_reg <= '0;
            src_latch_reg <= '0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            pending_reg   <= pending_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_index_reg <= out_index_next;
            if (cmd.accept && is_data && at_source)
            begin
                src_latch_reg <= $signed(in_source_amp);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit)
        begin
            p_reg <= p_new;
        end
    end

    // Line stores.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW:0]   off);
        logic [AW+1:0] s;
        s = (AW + 2)'(base) + (AW + 2)'(off);
        if (s >= (AW + 2)'(RING))
        begin
            s = s - (AW + 2)'(RING);
        end
        return s[AW-1:0];
    endfunction

    logic [AW:0]       w_ext, off_u, off_c;
    logic [AW-1:0]     raddr_u, raddr_c;
    logic [DATA_W-1:0] rdata_u, rdata_o;
    logic [COEF_W-1:0] rdata_c;
    logic              wr_en;

    assign w_ext = (AW + 1)'(eff_w);
    assign wr_en = cmd.accept && is_data;

    always_comb
    begin
        case (cmd.rd_idx)
            RD_CENTER: off_u = '0;
            RD_RIGHT:  off_u = (AW + 1)'(1);
            RD_LEFT:   off_u = (AW + 1)'(RING - 1);
            RD_DOWN:   off_u = w_ext;
            RD_UP:     off_u = (AW + 1)'(RING) - w_ext;
            default:   off_u = '0;
        endcase
        case (cmd.rd_idx)
            RD_CENTER: off_c = '0;
            RD_RIGHT:  off_c = (AW + 1)'(RING - 1);
            RD_LEFT:   off_c = (AW + 1)'(RING) - w_ext;
            RD_DOWN:   off_c = (AW + 1)'(RING) - w_ext - (AW + 1)'(1);
            default:   off_c = '0;
        endcase
    end

    assign raddr_u = slot(p_reg, off_u);
    assign raddr_c = slot(p_reg, off_c);

    wesp_ram #(.WIDTH(DATA_W), .DEPTH(RING)) u_prev_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (in_u_prev),
        .raddr (raddr_u),
        .rdata (rdata_u)
    );

    wesp_ram #(.WIDTH(COEF_W), .DEPTH(RING)) u_coef_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (in_medium_coef),
        .raddr (raddr_c),
        .rdata (rdata_c)
    );

    wesp_ram #(.WIDTH(DATA_W), .DEPTH(RING)) u_old_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (in_u_old),
        .raddr (p_reg),
        .rdata (rdata_o)
    );

    // Neighborhood capture; read data returns in the cycle after the address.
    logic                     rd_go_d_reg;
    logic [PHASE_W-1:0]       rd_idx_d_reg;
    logic signed [DATA_W-1:0] u_c, u_r, u_l, u_d, u_u, uo;
    logic [COEF_W-1:0]        c_c, c_l, c_u, c_ul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_go_d_reg  <= 1'b0;
            rd_idx_d_reg <= RD_CENTER;
        end
        else
        begin
            rd_go_d_reg  <= cmd.rd_go;
            rd_idx_d_reg <= cmd.rd_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_go_d_reg)
        begin
            case (rd_idx_d_reg)
                RD_CENTER:
                begin
                    u_c <= $signed(rdata_u);
                    c_c <= rdata_c;
                    uo  <= $signed(rdata_o);
                end
                RD_RIGHT:
                begin
                    u_r <= $signed(rdata_u);
                    c_l <= rdata_c;
                end
                RD_LEFT:
                begin
                    u_l <= $signed(rdata_u);
                    c_u <= rdata_c;
                end
                RD_DOWN:
                begin
                    u_d  <= $signed(rdata_u);
                    c_ul <= rdata_c;
                end
                RD_UP:   u_u <= $signed(rdata_u);
                default: ;
            endcase
        end
    end

    // Row and column of the result.
    logic [OI_W-1:0]  out_row;
    logic [DIM_W-1:0] out_col;
    logic             div_done;

    wesp_div #(.N(OI_W), .D(DIM_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.accept && emit),
        .dividend  (out_index_reg),
        .divisor   (eff_w),
        .quotient  (out_row),
        .remainder (out_col),
        .done      (div_done)
    );

    // Arithmetic.
    function automatic logic signed [35:0] dprod(input logic signed [32:0] d,
                                                 input logic [31:0] s);
        logic signed [65:0] m;
        m = d * $signed({1'b0, s});
        return 36'(m >>> 30);
    endfunction

    function automatic logic signed [53:0] hmul(input logic signed [36:0] a,
                                                input logic [15:0] h);
        logic signed [53:0] m;
        m = a * $signed({1'b0, h});
        return m;
    endfunction

    logic signed [35:0] px1, px2, py1, py2;
    logic signed [33:0] base_reg;
    logic signed [32:0] src_term_reg;
    logic signed [53:0] xhi, xlo, yhi, ylo;
    logic signed [45:0] xterm, yterm;
    logic signed [36:0] xt, yt;
    logic signed [64:0] src_m;

    assign xt    = 37'(px1) + 37'(px2);
    assign yt    = 37'(py1) + 37'(py2);
    assign src_m = src_latch_reg * $signed({1'b0, tau_sq_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            px1 <= dprod(33'(u_r) - 33'(u_c), 32'(c_u) + 32'(c_c));
            px2 <= dprod(33'(u_l) - 33'(u_c), 32'(c_ul) + 32'(c_l));
            py1 <= dprod(33'(u_d) - 33'(u_c), 32'(c_l) + 32'(c_c));
            py2 <= dprod(33'(u_u) - 33'(u_c), 32'(c_ul) + 32'(c_u));
            base_reg     <= (34'(u_c) <<< 1) - 34'(uo);
            src_term_reg <= 33'(src_m >>> 32);
        end
        if (cmd.mul2)
        begin
            xhi <= hmul(xt, coef_x_reg[31:16]);
            xlo <= hmul(xt, coef_x_reg[15:0]);
            yhi <= hmul(yt, coef_y_reg[31:16]);
            ylo <= hmul(yt, coef_y_reg[15:0]);
        end
        if (cmd.mul3)
        begin
            xterm <= 46'((xhi + (xlo >>> 16)) >>> 8);
            yterm <= 46'((yhi + (ylo >>> 16)) >>> 8);
        end
    end

    logic               boundary, src_hit, last;
    logic signed [47:0] sum, res;
    logic [OI_W-1:0]    total;
    logic [DATA_W-1:0]  u_new_val;

    assign boundary = (out_row == '0) || (out_col == '0)
                   || (out_row >= OI_W'(eff_h - 1'b1))
                   || (out_col >= (eff_w - 1'b1));
    assign src_hit  = (out_row == OI_W'(src_row_reg)) && (out_col == DIM_W'(src_col_reg));
    assign sum      = 48'(base_reg) + 48'(xterm) + 48'(yterm)
                    + (src_hit ? 48'(src_term_reg) : 48'sd0);
    assign res      = boundary ? 48'(uo) : sum;
    assign u_new_val = (res > 48'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                       (res < -48'sh8000_0000) ? 32'h8000_0000 : res[DATA_W-1:0];
    assign total    = OI_W'(eff_w) * OI_W'(eff_h);
    assign last     = (out_index_reg + 1'b1) >= total;

    always_comb
    begin
        out_index_next = out_index_reg;
        if (cmd.fin)
        begin
            out_index_next = last ? '0 : out_index_reg + 1'b1;
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_data_reg <= u_new_val;
            out_last_reg <= last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_u_new       = out_data_reg;
    assign out_frame_end   = out_last_reg;
    assign status.emit_req = emit;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= AW'(RING - 1))
        else $error("pending count beyond ring size");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg < AW'(RING))
        else $error("write pointer outside ring");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> out_valid_reg)
        else $error("finished result not presented");

endmodule

[hdl/wave_equation_stencil_step.sv]
// One time step of a 2-D variable-coefficient wave equation over a grid streamed in
// raster order. Each cell goes into three line stores; the result for a cell leaves
// grid_width+1 cells later, and pad transfers (tuser high) flush pending results.
// A cell transfer that yields no result leaves the control idle. One that yields a result
// runs these steps while no new transfer is taken: the transfer, the 22-step divider
// that splits the output position into row and column (the five neighborhood reads
// through the read ports of the line stores run beside it), a wait state that sees the
// divider finish, then four arithmetic steps, the last once the output register is free.
// A finished result waits in the output register while the next transfer is taken.
module wave_equation_stencil_step
    import wesp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [127:0]       s_tdata,   // u_prev, u_old, medium_coef, source_amp, zero pad
    input  logic               s_tuser,   // op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // u_new
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    wesp_cmd_t    cmd;
    wesp_status_t status;

    wesp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wesp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_tuser),
        .in_u_prev      (s_tdata[31:0]),
        .in_u_old       (s_tdata[63:32]),
        .in_medium_coef (s_tdata[94:64]),
        .in_source_amp  (s_tdata[126:95]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_u_new      (m_tdata),
        .out_frame_end  (m_tlast)
    );

endmodule

[dv/wave_equation_stencil_step_checker.sv]
`timescale 1ns / 1ps

module wave_equation_stencil_step_checker
    import wesp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [127:0]       s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [DATA_W-1:0]  m_tdata,
    input  logic               m_tlast,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output int                 errors,
    output int                 waiting,
    output int                 results_seen
);

    localparam int LINE_MAX = 1024;
    localparam int RING     = 2 * LINE_MAX + 4;

    typedef struct packed {
        logic [DATA_W-1:0] u_new;
        logic              frame_end;
    } cell_result_t;

    logic [31:0] u_ring [RING];
    logic [31:0] c_ring [RING];
    logic [31:0] o_ring [RING];

    int wr_ptr;
    int n_pend;
    int in_row;
    int in_col;
    int out_idx;
    logic signed [31:0] src_held;
    logic [10:0] grid_w;
    logic [10:0] grid_h;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] tsq;
    logic [9:0]  src_row;
    logic [9:0]  src_col;
    cell_result_t stencil_q[$];

    assign waiting = stencil_q.size();

    function automatic int used_w();
        return (grid_w < 3) ? 3 : ((grid_w > LINE_MAX) ? LINE_MAX : int'(grid_w));
    endfunction

    function automatic int used_h();
        return (grid_h < 3) ? 3 : ((grid_h > LINE_MAX) ? LINE_MAX : int'(grid_h));
    endfunction

    function automatic int ring_slot(input int p, input int d);
        return (p + RING + d) % RING;
    endfunction

    function automatic logic signed [127:0] u_at(input int p, input int d);
        logic signed [127:0] v;
        v = $signed(u_ring[ring_slot(p, d)]);
        return v;
    endfunction

    function automatic logic signed [127:0] c_at(input int p, input int d);
        return $signed({96'd0, c_ring[ring_slot(p, d)]});
    endfunction

    // Exact floor of a*b / 2^s; the arithmetic shift of a signed value floors.
    function automatic logic signed [127:0] scaled(input logic signed [127:0] a,
                                                   input logic signed [127:0] b,
                                                   input int s);
        logic signed [127:0] prod;
        prod = a * b;
        return prod >>> s;
    endfunction

    function automatic cell_result_t next_cell();
        int w;
        int h;
        int p;
        int r;
        int c;
        logic signed [127:0] uo;
        logic signed [127:0] uc;
        logic signed [127:0] pc;
        logic signed [127:0] pl;
        logic signed [127:0] pu;
        logic signed [127:0] pul;
        logic signed [127:0] xt;
        logic signed [127:0] yt;
        logic signed [127:0] res;
        cell_result_t out;
        w = used_w();
        h = used_h();
        p = (wr_ptr + RING - n_pend) % RING;
        r = out_idx / w;
        c = out_idx % w;
        uo = $signed(o_ring[p]);
        if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1) begin
            res = uo;
        end
        else begin
            uc = u_at(p, 0);
            pc = c_at(p, 0);
            pl = c_at(p, -1);
            pu = c_at(p, -w);
            pul = c_at(p, -w - 1);
            xt = scaled(u_at(p, 1) - uc, pu + pc, 30) + scaled(u_at(p, -1) - uc, pul + pl, 30);
            yt = scaled(u_at(p, w) - uc, pl + pc, 30) + scaled(u_at(p, -w) - uc, pul + pu, 30);
            res = 2 * uc - uo + scaled(xt, $signed({96'd0, cx}), 24)
                + scaled(yt, $signed({96'd0, cy}), 24);
            if (r == src_row && c == src_col)
                res = res + scaled($signed({{96{src_held[31]}}, src_held}),
                                   $signed({96'd0, tsq}), 32);
        end
        if (res > 128'sd2147483647)
            res = 128'sd2147483647;
        if (res < -128'sd2147483648)
            res = -128'sd2147483648;
        out.u_new = res[31:0];
        out.frame_end = (out_idx >= w * h - 1);
        out_idx = (out_idx + 1 >= w * h) ? 0 : out_idx + 1;
        n_pend--;
        return out;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n) begin
            wr_ptr = 0;
            n_pend = 0;
            in_row = 0;
            in_col = 0;
            out_idx = 0;
            src_held = '0;
            grid_w = 11'd1024;
            grid_h = 11'd1024;
            cx = '0;
            cy = '0;
            tsq = '0;
            src_row = 10'd1;
            src_col = 10'd1;
            errors = 0;
            results_seen = 0;
            stencil_q.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (stencil_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: u_new=%h last=%b",
                                 m_tdata, m_tlast);
                end
                else begin
                    want = stencil_q.pop_front();
                    if (want.u_new !== m_tdata || want.frame_end !== m_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d mismatch: expected u_new=%h last=%b, got %h %b",
                                     results_seen, want.u_new, want.frame_end, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == 1'b0) begin
                    u_ring[wr_ptr] = s_tdata[31:0];
                    o_ring[wr_ptr] = s_tdata[63:32];
                    c_ring[wr_ptr] = {1'b0, s_tdata[94:64]};
                    if (in_row == src_row && in_col == src_col)
                        src_held = s_tdata[126:95];
                    if (in_col + 1 >= used_w()) begin
                        in_col = 0;
                        in_row = (in_row + 1 >= used_h()) ? 0 : in_row + 1;
                    end
                    else begin
                        in_col++;
                    end
                    wr_ptr = (wr_ptr + 1) % RING;
                    if (n_pend < RING - 1)
                        n_pend++;
                    if (n_pend > used_w() + 1)
                        stencil_q.push_back(next_cell());
                end
                else if (n_pend > 0) begin
                    stencil_q.push_back(next_cell());
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_GRID_WIDTH:  grid_w = cfg_data[10:0];
                    REG_GRID_HEIGHT: grid_h = cfg_data[10:0];
                    REG_COEF_X:      cx = cfg_data;
                    REG_COEF_Y:      cy = cfg_data;
                    REG_TAU_SQ:      tsq = cfg_data;
                    REG_SOURCE_ROW:  src_row = cfg_data[9:0];
                    REG_SOURCE_COL:  src_col = cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/wave_equation_stencil_step_tb.sv]
`timescale 1ns / 1ps

module wave_equation_stencil_step_tb
    import wesp_pkg::*;
;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic OP_CELL = 1'b0;
    localparam logic OP_PAD  = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [127:0]       s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [DATA_W-1:0]  m_tdata;
    logic               m_tlast;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int                 errors;
    int                 waiting;
    int                 results_seen;

    int gap_pct;
    int stall_pct;
    int sent;
    int frames;
    int settings;
    int cur_w;
    int cur_h;

    wave_equation_stencil_step u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wave_equation_stencil_step_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .waiting      (waiting),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic op, input logic [31:0] up, input logic [31:0] uo,
                             input logic [30:0] mc, input logic [31:0] sa);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, sa, mc, uo, up};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
            2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom() >>> $urandom_range(2, 12);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(0, 1 << 25);
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic set_grid(input logic [10:0] w, input logic [10:0] h, input logic [31:0] kx,
                            input logic [31:0] ky, input logic [31:0] ts,
                            input logic [9:0] sr, input logic [9:0] sc);
        logic [IDX_W-1:0] idx [7];
        logic [CFG_W-1:0] val [7];
        idx = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_COEF_X, REG_COEF_Y,
                REG_TAU_SQ, REG_SOURCE_ROW, REG_SOURCE_COL};
        val = '{32'(w), 32'(h), kx, ky, ts, 32'(sr), 32'(sc)};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_w = (w < 3) ? 3 : ((w > 1024) ? 1024 : int'(w));
        cur_h = (h < 3) ? 3 : ((h > 1024) ? 1024 : int'(h));
        settings++;
    endtask

    task automatic flush_frame();
        repeat (cur_w + 1)
            send_item(OP_PAD, $urandom(), $urandom(), 31'($urandom()), $urandom());
        frames++;
    endtask

    task automatic random_frame(input bit hold_mid);
        int n;
        n = cur_w * cur_h;
        for (int i = 0; i < n; i++) begin
            if (hold_mid && i == n / 2) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (waiting != 0)
                    @(negedge clk);
                @(posedge clk);
            end
            send_item(OP_CELL, pick_word(), pick_word(),
                      ($urandom_range(1)) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 30)),
                      pick_word());
        end
        flush_frame();
    endtask

    initial
    begin
        logic [31:0] ext [4];
        logic [10:0] w;
        logic [10:0] h;
        int count_base;
        ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gap_pct = 6;
        stall_pct = 60;
        sent = 0;
        frames = 0;
        settings = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A pad with nothing pending yields no result.
        send_item(OP_PAD, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 32'hffffffff);
        wait_drained();

        // Smallest grid, full-scale coefficients, extreme values, with corners opposing the center.
        set_grid(11'd3, 11'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 10'd1, 10'd1);
        for (int i = 0; i < 9; i++)
            send_item(OP_CELL, (i == 4) ? 32'h80000000 : ext[i % 2], ext[(i + 1) % 4],
                      31'h7fffffff, (i == 4) ? 32'h80000000 : 32'h7fffffff);
        flush_frame();
        wait_drained();

        // Clamped sizes, source on a corner, zero coefficients.
        set_grid(11'd0, 11'd2, 32'd0, 32'd0, 32'h80000000, 10'd0, 10'd0);
        for (int i = 0; i < 9; i++)
            send_item(OP_CELL, ext[i % 4], ext[3 - (i % 4)], 31'd0, 32'h7fffffff);
        flush_frame();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data <= 32'hffffffff;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);

        count_base = sent;
        while (sent - count_base < 1450) begin
            if (sent - count_base < 480) begin
                gap_pct = 6;
                stall_pct = 60;
            end
            else if (sent - count_base < 960) begin
                gap_pct = 60;
                stall_pct = 6;
            end
            else begin
                gap_pct = 0;
                stall_pct = 0;
            end
            w = ($urandom_range(7) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 9));
            h = ($urandom_range(7) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8));
            set_grid(w, h, pick_coef(), pick_coef(), $urandom(),
                     ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 4)),
                     ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 5)));
            random_frame(frames % 9 == 4);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(OP_PAD, $urandom(), $urandom(), 31'($urandom()), $urandom());
            wait_drained();
        end

        $display("covered %0d frames under %0d register settings, %0d input transfers",
                 frames, settings, sent);
        $display("and %0d result transfers checked against the predicted stencil",
                 results_seen);
        if (errors == 0)
            $display("wave_equation_stencil_step_tb: done, clean");
        else
            $display("wave_equation_stencil_step_tb: done, errors");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("wave_equation_stencil_step_tb: done, errors");
        $finish;
    end

endmodule

[wave_equation_stencil_step.f]
hdl/wesp_pkg.sv
hdl/wesp_ram.sv
hdl/wesp_div.sv
hdl/wesp_ctrl.sv
hdl/wesp_dp.sv
hdl/wave_equation_stencil_step.sv
dv/wave_equation_stencil_step_checker.sv
dv/wave_equation_stencil_step_tb.sv
